>>> hw/rtl/mtbsm_pkg.sv
// shared opcode, access code and width constants for the byte stack machine
`default_nettype none
package mtbsm_pkg;

    // access codes of an input transfer
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // instruction opcodes
    localparam logic [7:0] OP_NOP  = 8'd0;
    localparam logic [7:0] OP_ORG  = 8'd1;
    localparam logic [7:0] OP_EQU  = 8'd2;
    localparam logic [7:0] OP_JMP  = 8'd3;
    localparam logic [7:0] OP_JMPZ = 8'd4;
    localparam logic [7:0] OP_PSHL = 8'd5;
    localparam logic [7:0] OP_PSH  = 8'd6;
    localparam logic [7:0] OP_PSHI = 8'd7;
    localparam logic [7:0] OP_POP  = 8'd8;
    localparam logic [7:0] OP_POPI = 8'd9;
    localparam logic [7:0] OP_ADD  = 8'd10;
    localparam logic [7:0] OP_SUB  = 8'd11;
    localparam logic [7:0] OP_INC  = 8'd12;
    localparam logic [7:0] OP_DEC  = 8'd13;
    localparam logic [7:0] OP_AND  = 8'd14;
    localparam logic [7:0] OP_OR   = 8'd15;
    localparam logic [7:0] OP_XOR  = 8'd16;
    localparam logic [7:0] OP_NOT  = 8'd17;
    localparam logic [7:0] OP_ROR  = 8'd18;
    localparam logic [7:0] OP_ROL  = 8'd19;
    localparam logic [7:0] OP_PIP  = 8'd20;
    localparam logic [7:0] OP_PDP  = 8'd21;
    localparam logic [7:0] OP_DUP  = 8'd22;
    localparam logic [7:0] OP_SAY  = 8'd23;

    // widths fixed by the transfer fields
    localparam int BYTE_W  = 8;
    localparam int DEPTH_W = 5;
    localparam int EN_W    = 4;

endpackage
`default_nettype wire

>>> hw/rtl/multithread_byte_stack_machine_top.sv
// multithread byte stack machine: sequencer, heap, stacks and result register
`default_nettype none
// A tick runs one instruction on each thread enabled in thread_enable, thread 0 first, and
// returns one result per thread index below min(THREAD_COUNT, 4); the final one has last set.
// All heap reads go through the single read port of the heap memory and all stack
// reads through the single read port of the stack memory, so an enabled thread steps
// through fetch, up to two pops, operand fetch, up to two indirect reads, execute and
// result, and a disabled thread goes straight to its result. A heap write or unused access
// code also goes straight to its result, a heap read through a read wait. The input is
// stalled until the last result of the current transfer is loaded into the output register.
module multithread_byte_stack_machine_top #(
    parameter int HEAP_BYTES   = 256,
    parameter int STACK_DEPTH  = 16,
    parameter int THREAD_COUNT = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [mtbsm_pkg::EN_W-1:0]   i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [1:0]                   i_func,
    input  wire logic [mtbsm_pkg::BYTE_W-1:0] i_addr,
    input  wire logic [mtbsm_pkg::BYTE_W-1:0] i_data,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_thread_index,
    output logic                              o_executed,
    output logic                              o_said,
    output logic [mtbsm_pkg::BYTE_W-1:0]      o_say_addr,
    output logic [mtbsm_pkg::BYTE_W-1:0]      o_say_size,
    output logic [mtbsm_pkg::BYTE_W-1:0]      o_read_data,
    output logic [mtbsm_pkg::BYTE_W-1:0]      o_abs_pc,
    output logic [mtbsm_pkg::DEPTH_W-1:0]     o_stack_depth,
    output logic                              o_last
);
    import mtbsm_pkg::*;

    localparam int HW       = $clog2(HEAP_BYTES);
    localparam int HRECIP   = 65536 / HEAP_BYTES;
    localparam int TW       = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int CW       = $clog2(STACK_DEPTH + 1);
    localparam int SWORDS   = THREAD_COUNT * STACK_DEPTH;
    localparam int SAW      = (SWORDS > 1) ? $clog2(SWORDS) : 1;
    localparam int REPORTED = (THREAD_COUNT < 4) ? THREAD_COUNT : 4;

    typedef enum logic [3:0] {
        S_IDLE, S_RDW, S_THR, S_OP, S_POP1, S_POP1D, S_POP2, S_POP2D,
        S_FET, S_FETD, S_IND, S_INDD, S_EXE, S_OUT
    } t_state;

    // heap offset wrap: reciprocal estimate then one correction step
    function automatic logic [HW-1:0] f_wrap(input logic [8:0] x);
        int q;
        int r;
        q = (int'(x) * HRECIP) >>> 16;
        r = int'(x) - q * HEAP_BYTES;
        if (r >= HEAP_BYTES) r = r - HEAP_BYTES;
        return HW'(r);
    endfunction

    // flat stack memory address of a thread's slot
    function automatic logic [SAW-1:0] f_saddr(input logic [TW-1:0] t, input logic [CW-1:0] i);
        return SAW'(int'(t) * STACK_DEPTH + int'(i));
    endfunction

    t_state                r_state;
    logic [TW-1:0]         r_t;
    logic [EN_W-1:0]       r_cfg;
    logic [BYTE_W-1:0]     r_start [THREAD_COUNT];
    logic [BYTE_W-1:0]     r_pc    [THREAD_COUNT];
    logic [CW-1:0]         r_cnt   [THREAD_COUNT];
    logic [BYTE_W-1:0]     r_op, r_a, r_b, r_d, r_e;
    logic                  r_z, r_ind2, r_tick, r_exec, r_said;
    logic [BYTE_W-1:0]     r_rdat;

    // heap memory with per-byte written flags
    logic [BYTE_W-1:0]     heap_mem [HEAP_BYTES];
    logic [HEAP_BYTES-1:0] r_hvld;
    logic [BYTE_W-1:0]     r_hq;
    logic                  r_hq_vld;
    logic [BYTE_W-1:0]     hq;

    // stack memory
    logic [BYTE_W-1:0]     stk_mem [SWORDS];
    logic [BYTE_W-1:0]     r_sq;

    logic [BYTE_W-1:0]     cur_start, cur_pc, off, push_val;
    logic [CW-1:0]         cur_cnt;
    logic [1:0]            t2;
    logic                  cur_en, pop2, pop1, is_top, need_fet, need_ind, is_push, stk_room;
    logic                  h_we, s_we, accept, out_load, t_last;
    logic [HW-1:0]         thr_idx, rd_idx, h_widx;
    logic [BYTE_W-1:0]     h_wdata;
    logic [SAW-1:0]        s_raddr, s_waddr;

    assign cur_start = r_start[r_t];
    assign cur_pc    = r_pc[r_t];
    assign cur_cnt   = r_cnt[r_t];
    assign t2        = 2'(r_t);
    assign cur_en    = r_cfg[t2];
    assign t_last    = (int'(r_t) == REPORTED - 1);
    assign stk_room  = (cur_cnt < CW'(STACK_DEPTH));
    assign hq        = r_hq_vld ? r_hq : '0;
    assign accept    = i_valid && !o_stall;
    assign out_load  = (r_state == S_OUT) && (!o_valid || !i_stall);
    assign o_stall   = (r_state != S_IDLE);

    // opcode class decode
    always_comb begin
        pop2     = r_op inside {OP_EQU, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SAY};
        pop1     = r_op inside {OP_JMPZ, OP_POP, OP_POPI, OP_INC, OP_DEC, OP_NOT,
                                OP_ROR, OP_ROL};
        is_top   = (r_op == OP_DUP);
        need_fet = r_op inside {OP_JMP, OP_JMPZ, OP_PSHL, OP_PSH, OP_PSHI, OP_POP, OP_POPI,
                                OP_ROR, OP_ROL, OP_PIP, OP_PDP};
        need_ind = r_op inside {OP_PSH, OP_PSHI, OP_POPI, OP_PIP, OP_PDP};
        is_push  = r_op inside {OP_EQU, OP_PSHL, OP_PSH, OP_PSHI, OP_ADD, OP_SUB, OP_INC,
                                OP_DEC, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_ROR, OP_ROL,
                                OP_DUP};
    end

    // shared alu for the pushed value
    always_comb begin
        case (r_op)
            OP_EQU:  push_val = (r_a == r_b) ? 8'd1 : 8'd0;
            OP_PSHL: push_val = r_d;
            OP_PSH:  push_val = r_e;
            OP_PSHI: push_val = r_e;
            OP_ADD:  push_val = r_a + r_b;
            OP_SUB:  push_val = r_a - r_b;
            OP_INC:  push_val = r_a + 8'd1;
            OP_DEC:  push_val = r_a - 8'd1;
            OP_AND:  push_val = r_a & r_b;
            OP_OR:   push_val = r_a | r_b;
            OP_XOR:  push_val = r_a ^ r_b;
            OP_NOT:  push_val = ~r_a;
            OP_ROR:  push_val = r_a >> r_d[2:0];
            OP_ROL:  push_val = r_a << r_d[2:0];
            default: push_val = r_a;
        endcase
    end

    // thread heap address: one adder and wrap shared by all thread accesses
    always_comb begin
        case (r_state)
            S_IND:   off = r_d;
            S_EXE:   off = (r_op == OP_POPI) ? r_e : r_d;
            default: off = cur_pc;
        endcase
    end
    assign thr_idx = f_wrap(9'(cur_start) + 9'(off));
    assign rd_idx  = (r_state == S_IDLE) ? f_wrap({1'b0, i_addr}) : thr_idx;

    // heap write port
    always_comb begin
        h_we    = 1'b0;
        h_widx  = thr_idx;
        h_wdata = r_a;
        if (r_state == S_IDLE) begin
            h_we    = accept && (i_func == FUNC_WRITE);
            h_widx  = f_wrap({1'b0, i_addr});
            h_wdata = i_data;
        end else if (r_state == S_EXE) begin
            h_we = r_op inside {OP_POP, OP_POPI, OP_PIP, OP_PDP};
            if (r_op == OP_PIP) h_wdata = r_e + 8'd1;
            if (r_op == OP_PDP) h_wdata = r_e - 8'd1;
        end
    end

    // stack port
    assign s_raddr = f_saddr(r_t, CW'(cur_cnt - 1'b1));
    assign s_waddr = f_saddr(r_t, cur_cnt);
    assign s_we    = (r_state == S_EXE) && is_push && stk_room;

    always_ff @(posedge i_clk) begin
        if (h_we) heap_mem[h_widx] <= h_wdata;
        r_hq <= heap_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) stk_mem[s_waddr] <= push_val;
        r_sq <= stk_mem[s_raddr];
    end

    // written flags of the heap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld   <= '0;
            r_hq_vld <= 1'b0;
        end else begin
            if (h_we) r_hvld[h_widx] <= 1'b1;
            r_hq_vld <= r_hvld[rd_idx] && !(h_we && h_widx == rd_idx);
        end
    end

    // sequencer, thread state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t     <= '0;
            r_cfg   <= EN_W'(1);
            for (int i = 0; i < THREAD_COUNT; i++) begin
                r_start[i] <= '0;
                r_pc[i]    <= '0;
                r_cnt[i]   <= '0;
            end
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (o_valid && !i_stall && !out_load) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_exec <= 1'b0;
                    r_said <= 1'b0;
                    r_a    <= '0;
                    r_b    <= '0;
                    r_rdat <= '0;
                    r_tick <= accept && (i_func == FUNC_TICK);
                    if (accept) begin
                        r_t <= '0;
                        if (i_func == FUNC_TICK) begin
                            r_state <= S_THR;
                        end else if (i_func == FUNC_READ) begin
                            r_state <= S_RDW;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RDW: begin
                    r_rdat  <= hq;
                    r_state <= S_OUT;
                end
                S_THR: begin
                    r_exec <= cur_en;
                    r_said <= 1'b0;
                    r_a    <= '0;
                    r_b    <= '0;
                    if (cur_en) begin
                        r_pc[r_t]  <= cur_pc + 8'd1;
                        r_state    <= S_OP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OP: begin
                    r_op    <= hq;
                    r_state <= S_POP1;
                end
                S_POP1: begin
                    r_z <= (cur_cnt == '0);
                    if ((pop1 || pop2) && cur_cnt != '0) r_cnt[r_t] <= cur_cnt - 1'b1;
                    r_state <= (pop1 || pop2 || is_top) ? S_POP1D : S_FET;
                end
                S_POP1D: begin
                    r_a     <= r_z ? '0 : r_sq;
                    r_state <= pop2 ? S_POP2 : S_FET;
                end
                S_POP2: begin
                    r_z <= (cur_cnt == '0);
                    if (cur_cnt != '0) r_cnt[r_t] <= cur_cnt - 1'b1;
                    r_state <= S_POP2D;
                end
                S_POP2D: begin
                    r_b     <= r_z ? '0 : r_sq;
                    r_state <= S_FET;
                end
                S_FET: begin
                    r_state <= need_fet ? S_FETD : S_EXE;
                end
                S_FETD: begin
                    r_d <= hq;
                    if (r_op == OP_JMP || (r_op == OP_JMPZ && r_a == '0)) begin
                        r_pc[r_t] <= hq;
                    end else begin
                        r_pc[r_t] <= cur_pc + 8'd1;
                    end
                    r_ind2  <= (r_op == OP_PSHI);
                    r_state <= need_ind ? S_IND : S_EXE;
                end
                S_IND: begin
                    r_state <= S_INDD;
                end
                S_INDD: begin
                    r_e <= hq;
                    if (r_ind2) begin
                        r_d     <= hq;
                        r_ind2  <= 1'b0;
                        r_state <= S_IND;
                    end else begin
                        r_state <= S_EXE;
                    end
                end
                S_EXE: begin
                    if (r_op == OP_ORG) begin
                        r_start[r_t] <= cur_start + cur_pc - 8'd1;
                        r_pc[r_t]    <= 8'd1;
                    end
                    if (s_we) r_cnt[r_t] <= cur_cnt + 1'b1;
                    r_said  <= (r_op == OP_SAY);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        o_valid        <= 1'b1;
                        o_thread_index <= r_tick ? t2 : 2'd0;
                        o_executed     <= r_exec;
                        o_said         <= r_said;
                        o_say_addr     <= r_said ? r_a : '0;
                        o_say_size     <= r_said ? r_b : '0;
                        o_read_data    <= r_rdat;
                        o_abs_pc       <= r_tick ? cur_start + cur_pc : '0;
                        o_stack_depth  <= r_tick ? DEPTH_W'(cur_cnt) : '0;
                        o_last         <= !r_tick || t_last;
                        if (r_tick && !t_last) begin
                            r_t     <= r_t + 1'b1;
                            r_state <= S_THR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // an instruction only executes on an enabled thread
    a_exec_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXE) |-> (r_exec && cur_en))
        else $error("instruction executed on a disabled thread");

    // a disabled thread never reports a say event
    a_say_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_said) |-> o_executed)
        else $error("say reported without execution");

    // stack fill stays within its depth
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a loaded tick result that is not the last moves the sequencer on to the next thread
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_tick && !t_last) |=> (r_state == S_THR))
        else $error("tick did not advance to next thread");
`endif

endmodule
`default_nettype wire

>>> dv/tb_multithread_byte_stack_machine_top.sv
// self-checking testbench for the multithread byte stack machine
`default_nettype none
module tb_multithread_byte_stack_machine_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mtbsm_pkg::*;

    localparam int HEAP_N  = 256;
    localparam int STK_N   = 16;
    localparam int THR_N   = 4;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic [1:0] thread_index;
        logic       executed;
        logic       said;
        logic [7:0] say_addr;
        logic [7:0] say_size;
        logic [7:0] read_data;
        logic [7:0] abs_pc;
        logic [4:0] stack_depth;
        logic       last;
    } result_t;

    logic       i_clk, i_rst_n, i_cfg_we, i_valid, i_stall;
    logic [3:0] i_cfg_wdata;
    logic [1:0] i_func;
    logic [7:0] i_addr, i_data;
    logic       o_stall, o_valid, o_executed, o_said, o_last;
    logic [1:0] o_thread_index;
    logic [7:0] o_say_addr, o_say_size, o_read_data, o_abs_pc;
    logic [4:0] o_stack_depth;

    multithread_byte_stack_machine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_func(i_func), .i_addr(i_addr),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall),
        .o_thread_index(o_thread_index), .o_executed(o_executed), .o_said(o_said),
        .o_say_addr(o_say_addr), .o_say_size(o_say_size), .o_read_data(o_read_data),
        .o_abs_pc(o_abs_pc), .o_stack_depth(o_stack_depth), .o_last(o_last)
    );

    // machine shadow state
    logic [7:0] heap_sh [HEAP_N];
    logic [7:0] base_sh [THR_N];
    logic [7:0] pc_sh   [THR_N];
    logic [7:0] stk_sh  [THR_N][STK_N];
    int         depth_sh [THR_N];
    logic [3:0] enable_sh;

    result_t pending_results[$];
    bit      failed;
    int      cycle_cnt;
    bit      hold_off;
    int      burst_left;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] thr_rd(int t, logic [7:0] off);
        return heap_sh[8'(base_sh[t] + off)];
    endfunction

    function automatic void thr_wr(int t, logic [7:0] off, logic [7:0] d);
        heap_sh[8'(base_sh[t] + off)] = d;
    endfunction

    function automatic void stk_push(int t, logic [7:0] v);
        if (depth_sh[t] < STK_N) begin
            stk_sh[t][depth_sh[t]] = v;
            depth_sh[t]++;
        end
    endfunction

    function automatic logic [7:0] stk_pop(int t);
        if (depth_sh[t] == 0) return 8'd0;
        depth_sh[t]--;
        return stk_sh[t][depth_sh[t]];
    endfunction

    function automatic logic [7:0] next_byte(int t);
        logic [7:0] v;
        v = thr_rd(t, pc_sh[t]);
        pc_sh[t]++;
        return v;
    endfunction

    // execute one instruction of thread t, fill say fields
    function automatic void exec_thread(int t, ref result_t r);
        logic [7:0] op, a, b, d;
        op = next_byte(t);
        case (op)
            OP_ORG: begin
                base_sh[t] = base_sh[t] + pc_sh[t] - 8'd1;
                pc_sh[t] = 8'd1;
            end
            OP_EQU: begin
                a = stk_pop(t); b = stk_pop(t); stk_push(t, (a == b) ? 8'd1 : 8'd0);
            end
            OP_JMP: pc_sh[t] = thr_rd(t, pc_sh[t]);
            OP_JMPZ: begin
                if (stk_pop(t) == 8'd0) pc_sh[t] = thr_rd(t, pc_sh[t]);
                else pc_sh[t]++;
            end
            OP_PSHL: stk_push(t, next_byte(t));
            OP_PSH:  stk_push(t, thr_rd(t, next_byte(t)));
            OP_PSHI: stk_push(t, thr_rd(t, thr_rd(t, next_byte(t))));
            OP_POP: begin
                d = next_byte(t); thr_wr(t, d, stk_pop(t));
            end
            OP_POPI: begin
                d = thr_rd(t, next_byte(t)); thr_wr(t, d, stk_pop(t));
            end
            OP_ADD: begin a = stk_pop(t); b = stk_pop(t); stk_push(t, a + b); end
            OP_SUB: begin a = stk_pop(t); b = stk_pop(t); stk_push(t, a - b); end
            OP_INC: stk_push(t, stk_pop(t) + 8'd1);
            OP_DEC: stk_push(t, stk_pop(t) - 8'd1);
            OP_AND: begin a = stk_pop(t); b = stk_pop(t); stk_push(t, a & b); end
            OP_OR:  begin a = stk_pop(t); b = stk_pop(t); stk_push(t, a | b); end
            OP_XOR: begin a = stk_pop(t); b = stk_pop(t); stk_push(t, a ^ b); end
            OP_NOT: stk_push(t, ~stk_pop(t));
            OP_ROR: begin a = stk_pop(t); d = next_byte(t); stk_push(t, a >> d[2:0]); end
            OP_ROL: begin a = stk_pop(t); d = next_byte(t); stk_push(t, a << d[2:0]); end
            OP_PIP: begin d = next_byte(t); thr_wr(t, d, thr_rd(t, d) + 8'd1); end
            OP_PDP: begin d = next_byte(t); thr_wr(t, d, thr_rd(t, d) - 8'd1); end
            OP_DUP: begin
                a = (depth_sh[t] == 0) ? 8'd0 : stk_sh[t][depth_sh[t] - 1];
                stk_push(t, a);
            end
            OP_SAY: begin
                a = stk_pop(t); b = stk_pop(t);
                r.said = 1'b1; r.say_addr = a; r.say_size = b;
            end
            default: ;
        endcase
    endfunction

    // work out the results of one accepted transfer
    function automatic void predict_transfer(logic [1:0] f, logic [7:0] ad, logic [7:0] dt);
        result_t r;
        if (f != FUNC_TICK) begin
            r = '0;
            if (f == FUNC_WRITE) heap_sh[ad] = dt;
            else if (f == FUNC_READ) r.read_data = heap_sh[ad];
            r.last = 1'b1;
            pending_results.push_back(r);
            return;
        end
        for (int t = 0; t < THR_N; t++) begin
            r = '0;
            r.thread_index = 2'(t);
            if (enable_sh[t]) begin
                r.executed = 1'b1;
                exec_thread(t, r);
            end
            r.abs_pc = base_sh[t] + pc_sh[t];
            r.stack_depth = 5'(depth_sh[t]);
            r.last = (t == THR_N - 1);
            pending_results.push_back(r);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        result_t got, exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_thread_index, o_executed, o_said, o_say_addr, o_say_size,
                    o_read_data, o_abs_pc, o_stack_depth, o_last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                failed = 1;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.thread_index != exp_r.thread_index)
                    $display("%0t: thread_index exp %0d got %0d", $realtime,
                             exp_r.thread_index, got.thread_index);
                if (got.executed != exp_r.executed)
                    $display("%0t: executed exp %0d got %0d", $realtime,
                             exp_r.executed, got.executed);
                if (got.said != exp_r.said)
                    $display("%0t: said exp %0d got %0d", $realtime, exp_r.said, got.said);
                if (got.say_addr != exp_r.say_addr)
                    $display("%0t: say_addr exp %h got %h", $realtime,
                             exp_r.say_addr, got.say_addr);
                if (got.say_size != exp_r.say_size)
                    $display("%0t: say_size exp %h got %h", $realtime,
                             exp_r.say_size, got.say_size);
                if (got.read_data != exp_r.read_data)
                    $display("%0t: read_data exp %h got %h", $realtime,
                             exp_r.read_data, got.read_data);
                if (got.abs_pc != exp_r.abs_pc)
                    $display("%0t: abs_pc exp %h got %h", $realtime, exp_r.abs_pc, got.abs_pc);
                if (got.stack_depth != exp_r.stack_depth)
                    $display("%0t: stack_depth exp %0d got %0d", $realtime,
                             exp_r.stack_depth, got.stack_depth);
                if (got.last != exp_r.last)
                    $display("%0t: last exp %0d got %0d", $realtime, exp_r.last, got.last);
                if (got != exp_r) failed = 1;
            end
        end
    end

    // receiver stall pattern, with forced hold-off stretches
    always @(posedge i_clk) begin
        int ph;
        ph = cycle_cnt % 64;
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_off) i_stall <= 1'b1;
        else if (ph < 20) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0);
    end

    // long receiver hold-off counted in cycles
    task automatic hold_receiver(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // send one transfer, with burst and gap idling
    task automatic send_item(logic [1:0] f, logic [7:0] ad, logic [7:0] dt, bit no_gap = 0);
        if (!no_gap) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_addr  <= ad;
        i_data  <= dt;
        do @(posedge i_clk); while (o_stall);
        predict_transfer(f, ad, dt);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_enable(logic [3:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        enable_sh = v;
    endtask

    // heap extremes, reads, unused access code
    task automatic test_direct_access();
        send_item(FUNC_READ, 8'h00, 8'h00);
        send_item(FUNC_WRITE, 8'hff, 8'hff);
        send_item(FUNC_READ, 8'hff, 8'h00);
        send_item(FUNC_WRITE, 8'hff, 8'h00);
        send_item(2'd3, 8'haa, 8'h55);
        send_item(FUNC_READ, 8'h55, 8'haa);
    endtask

    // small program touching every opcode, run on thread 0
    task automatic test_all_opcodes();
        logic [7:0] prog [$];
        prog = '{OP_PSHL, 8'd5, OP_PSHL, 8'd5, OP_EQU, OP_JMPZ, 8'd60, OP_PSHL, 8'd200,
                 OP_DUP, OP_ADD, OP_INC, OP_DEC, OP_NOT, OP_PSHL, 8'hf0, OP_AND, OP_PSHL, 8'h3,
                 OP_OR, OP_PSHL, 8'h81, OP_XOR, OP_ROR, 8'd9, OP_ROL, 8'd3, OP_PSHL, 8'd7,
                 OP_SUB, OP_POP, 8'd100, OP_PSH, 8'd100, OP_PSHI, 8'd101, OP_POPI, 8'd102,
                 OP_PIP, 8'd100, OP_PDP, 8'd101, OP_SAY, OP_SAY, 8'd200, OP_NOP, OP_JMP, 8'd50};
        for (int i = 0; i < prog.size(); i++) send_item(FUNC_WRITE, 8'(i), prog[i]);
        send_item(FUNC_WRITE, 8'd101, 8'd99);
        send_item(FUNC_WRITE, 8'd50, OP_ORG);
        for (int i = 0; i < 40; i++) send_item(FUNC_TICK, 8'(i), 8'(i));
    endtask

    // pile pushes to overflow, pops past empty, all thread enables
    task automatic test_stack_limits();
        write_enable(4'hf);
        for (int i = 0; i < 24; i++) send_item(FUNC_TICK, 8'h0, 8'h0);
        write_enable(4'h0);
        send_item(FUNC_TICK, 8'hff, 8'hff);
        write_enable(4'ha);
    endtask

    // random program images and random ticks under back-pressure
    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            for (int i = 0; i < 32; i++) begin
                logic [7:0] b;
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
                send_item(FUNC_WRITE, 8'($urandom), b);
            end
            if (p == 1) begin
                fork
                    hold_receiver(300);
                    for (int i = 0; i < 6; i++) send_item(FUNC_TICK, 8'h0, 8'h0, 1);
                join
            end
            for (int i = 0; i < 32; i++) begin
                case ($urandom_range(0, 5))
                    0: send_item(FUNC_READ, 8'($urandom), 8'($urandom));
                    1: send_item(2'($urandom), 8'($urandom), 8'($urandom));
                    default: send_item(FUNC_TICK, 8'($urandom), 8'($urandom));
                endcase
            end
            write_enable(4'($urandom));
        end
        write_enable(4'hf);
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = 0; i_valid = 0; i_stall = 0;
        i_func = 0; i_addr = 0; i_data = 0;
        failed = 0; cycle_cnt = 0; hold_off = 0; burst_left = 0;
        foreach (heap_sh[k]) heap_sh[k] = 8'd0;
        for (int t = 0; t < THR_N; t++) begin
            base_sh[t] = 0; pc_sh[t] = 0; depth_sh[t] = 0;
            for (int s = 0; s < STK_N; s++) stk_sh[t][s] = 0;
        end
        enable_sh = 4'h1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_direct_access();
        test_all_opcodes();
        test_stack_limits();
        test_random();
        wait_idle();
        if (!failed) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
